FILE: rtl/ssi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and widths for the segment/sphere intersection pipe
// Beat structs for both channels, the internal stage bundles and the derived
// widths of the exact integer datapath.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int COORD_W = 32;               // Q16.16 coordinate
  localparam int T_W     = 16;               // fraction bits of t
  localparam int RAD_W   = COORD_W - 1;
  localparam int DIFF_W  = COORD_W + 1;      // A-C, B-A
  localparam int HALF_W  = DIFF_W;           // limb of a split magnitude
  localparam int MAG_W   = 2 * HALF_W;       // |b|, |c|, a
  localparam int QUAD_W  = MAG_W + 1;        // signed b, c
  localparam int SQ_W    = 2 * MAG_W;        // b^2, a*c, disc
  localparam int ROOT_W  = MAG_W + T_W;      // sqrt(disc * 2^(2T))
  localparam int RADX_W  = 2 * ROOT_W;       // radicand
  localparam int REM_W   = ROOT_W + 2;
  localparam int NUM_W   = ROOT_W + 2;       // -b*S - R
  localparam int PROD_W  = T_W + 1 + DIFF_W; // k * d

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [MAG_W-1:0]   wide_t;
  typedef logic signed [QUAD_W-1:0]  qval_t;
  typedef logic signed [NUM_W-1:0]   nval_t;
  typedef logic signed [PROD_W-1:0]  pval_t;

  typedef struct packed {
    coord_t             start_x;
    coord_t             start_y;
    coord_t             start_z;
    coord_t             end_x;
    coord_t             end_y;
    coord_t             end_z;
    coord_t             center_x;
    coord_t             center_y;
    coord_t             center_z;
    logic [RAD_W-1:0]   radius;
  } in_beat_t;

  typedef struct packed {
    logic               hit;
    logic [T_W-1:0]     param_t;
    coord_t             point_x;
    coord_t             point_y;
    coord_t             point_z;
  } out_beat_t;

  // start point and direction, carried to the end for the contact point
  typedef struct packed {
    coord_t [2:0]       org;
    diff_t  [2:0]       dir;
  } geom_t;

  typedef struct packed {
    geom_t              geom;
    logic               miss;
    qval_t              b;
    logic [MAG_W-1:0]   a;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [SQ_W-1:0]    disc;
  } coef_t;

  typedef struct packed {
    side_t              side;
    logic [ROOT_W-1:0]  root;
    logic               rem_nz;
  } root_beat_t;

  typedef struct packed {
    geom_t              geom;
    logic               miss;
    logic [T_W-1:0]     k;
  } tval_t;

endpackage
`default_nettype wire

FILE: rtl/segment_sphere_intersect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_sphere_intersect: segment vs. sphere first-contact pipeline
// Top level: input skid register, four pipeline sections, output register.
// ----------------------------------------------------------------------------
// Takes one query beat per clock while the pipeline advances and returns one
// result beat per query, in order. A query passes the coefficient and
// discriminant section, the square root (one root bit per stage, exact over
// the full 164-bit radicand), the division that yields t (one bit per stage
// plus numerator and range check), and the contact point. All arithmetic is
// exact integer: t is floor(t * 2^16), the point is floored toward minus
// infinity, and a miss returns all-zero fields. The pipeline advances as a
// whole whenever the output register is empty or being taken; a one-beat
// skid register at the input keeps in_stall_o a plain flop, so one more
// query is taken while the output waits.
// ----------------------------------------------------------------------------
module segment_sphere_intersect
  import ssi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic       en;           // whole-pipe advance
  logic       accept;
  logic       skid_v_q;
  in_beat_t   skid_q;
  logic       pipe_v;
  in_beat_t   pipe_beat;

  logic       quad_v;
  coef_t      coef;
  logic       root_v;
  root_beat_t root_b;
  logic       quot_v;
  tval_t      tval;

  // output register is the last point stage
  assign en        = !out_valid_o || !out_stall_i;
  assign in_stall_o = skid_v_q;
  assign accept    = in_valid_i && !skid_v_q;

  // a parked beat goes first
  assign pipe_v    = skid_v_q || in_valid_i;
  assign pipe_beat = skid_v_q ? skid_q : in_beat_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (en) begin
      skid_v_q <= 1'b0;
    end else if (accept) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && accept) begin
      skid_q <= in_beat_i;
    end
  end

  ssi_quad u_quad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pipe_v),
    .beat_i  (pipe_beat),
    .valid_o (quad_v),
    .coef_o  (coef)
  );

  ssi_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (quad_v),
    .coef_i  (coef),
    .valid_o (root_v),
    .root_o  (root_b)
  );

  ssi_quot u_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (root_v),
    .root_i  (root_b),
    .valid_o (quot_v),
    .tval_o  (tval)
  );

  ssi_point u_point (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (quot_v),
    .tval_i  (tval),
    .valid_o (out_valid_o),
    .beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire

FILE: rtl/ssi_quad.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_quad: quadratic coefficients and discriminant
// Seven stages: differences, products, dot sums, magnitudes, limb products,
// limb sums, discriminant. Early misses are flagged on the way.
// ----------------------------------------------------------------------------
module ssi_quad
  import ssi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_beat_t beat_i,
  output logic     valid_o,
  output coef_t    coef_o
);

  logic [6:0] v_q;

  geom_t            geom1_q, geom1_d;
  diff_t            rel1_q [3];
  diff_t            rel1_d [3];
  logic [RAD_W-1:0] rad1_q;

  geom_t              geom2_q;
  wide_t              md2_q [3];
  wide_t              mm2_q [3];
  wide_t              dd2_q [3];
  wide_t              md2_d [3];
  wide_t              mm2_d [3];
  wide_t              dd2_d [3];
  logic [2*RAD_W-1:0] rr2_q, rr2_d;

  geom_t            geom3_q;
  qval_t            b3_q, c3_q, b3_d, c3_d;
  logic [MAG_W-1:0] a3_q, a3_d;
  logic             miss3_q, miss3_d;

  side_t            side4_q;
  logic [MAG_W-1:0] bm4_q, cm4_q, bm4_d, cm4_d;
  logic             cneg4_q;

  side_t            side5_q;
  logic             cneg5_q;
  logic [MAG_W-1:0] pb_hh5_q, pb_hl5_q, pb_ll5_q;
  logic [MAG_W-1:0] pc_hh5_q, pc_hl5_q, pc_lh5_q, pc_ll5_q;

  side_t            side6_q;
  logic             cneg6_q;
  logic [SQ_W-1:0]  bsq6_q, acm6_q, bsq6_d, acm6_d;

  side_t            side7_q, side7_d;
  logic [SQ_W-1:0]  disc7_q;
  logic [SQ_W:0]    disc7_d;

  always_comb begin
    geom1_d.org[0] = beat_i.start_x;
    geom1_d.org[1] = beat_i.start_y;
    geom1_d.org[2] = beat_i.start_z;
    geom1_d.dir[0] = diff_t'(beat_i.end_x) - diff_t'(beat_i.start_x);
    geom1_d.dir[1] = diff_t'(beat_i.end_y) - diff_t'(beat_i.start_y);
    geom1_d.dir[2] = diff_t'(beat_i.end_z) - diff_t'(beat_i.start_z);
    rel1_d[0]      = diff_t'(beat_i.start_x) - diff_t'(beat_i.center_x);
    rel1_d[1]      = diff_t'(beat_i.start_y) - diff_t'(beat_i.center_y);
    rel1_d[2]      = diff_t'(beat_i.start_z) - diff_t'(beat_i.center_z);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      md2_d[i] = rel1_q[i] * geom1_q.dir[i];
      mm2_d[i] = rel1_q[i] * rel1_q[i];
      dd2_d[i] = geom1_q.dir[i] * geom1_q.dir[i];
    end
    rr2_d = rad1_q * rad1_q;
  end

  always_comb begin
    b3_d    = qval_t'(md2_q[0]) + qval_t'(md2_q[1]) + qval_t'(md2_q[2]);
    c3_d    = qval_t'(mm2_q[0]) + qval_t'(mm2_q[1]) + qval_t'(mm2_q[2]) - qval_t'(rr2_q);
    a3_d    = $unsigned(dd2_q[0]) + $unsigned(dd2_q[1]) + $unsigned(dd2_q[2]);
    // outside and heading away, or a zero-length segment
    miss3_d = (!c3_d[QUAD_W-1] && c3_d != '0 && !b3_d[QUAD_W-1] && b3_d != '0) ||
              (a3_d == '0);
  end

  always_comb begin
    bm4_d = b3_q[QUAD_W-1] ? MAG_W'(-b3_q) : MAG_W'(b3_q);
    cm4_d = c3_q[QUAD_W-1] ? MAG_W'(-c3_q) : MAG_W'(c3_q);
  end

  always_comb begin
    bsq6_d = (SQ_W'(pb_hh5_q) << MAG_W) + (SQ_W'(pb_hl5_q) << (HALF_W + 1)) +
             SQ_W'(pb_ll5_q);
    acm6_d = (SQ_W'(pc_hh5_q) << MAG_W) +
             ((SQ_W'(pc_hl5_q) + SQ_W'(pc_lh5_q)) << HALF_W) + SQ_W'(pc_ll5_q);
  end

  always_comb begin
    // disc = b^2 - a*c with c carried as sign and magnitude
    if (cneg6_q) begin
      disc7_d = {1'b0, bsq6_q} + {1'b0, acm6_q};
    end else begin
      disc7_d = {1'b0, bsq6_q} - {1'b0, acm6_q};
    end
    side7_d      = side6_q;
    side7_d.miss = side6_q.miss | disc7_d[SQ_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geom1_q <= geom1_d;
      rel1_q  <= rel1_d;
      rad1_q  <= beat_i.radius;

      geom2_q <= geom1_q;
      md2_q   <= md2_d;
      mm2_q   <= mm2_d;
      dd2_q   <= dd2_d;
      rr2_q   <= rr2_d;

      geom3_q <= geom2_q;
      b3_q    <= b3_d;
      c3_q    <= c3_d;
      a3_q    <= a3_d;
      miss3_q <= miss3_d;

      side4_q.geom <= geom3_q;
      side4_q.miss <= miss3_q;
      side4_q.b    <= b3_q;
      side4_q.a    <= a3_q;
      bm4_q        <= bm4_d;
      cm4_q        <= cm4_d;
      cneg4_q      <= c3_q[QUAD_W-1];

      side5_q  <= side4_q;
      cneg5_q  <= cneg4_q;
      pb_hh5_q <= bm4_q[MAG_W-1:HALF_W] * bm4_q[MAG_W-1:HALF_W];
      pb_hl5_q <= bm4_q[MAG_W-1:HALF_W] * bm4_q[HALF_W-1:0];
      pb_ll5_q <= bm4_q[HALF_W-1:0] * bm4_q[HALF_W-1:0];
      pc_hh5_q <= side4_q.a[MAG_W-1:HALF_W] * cm4_q[MAG_W-1:HALF_W];
      pc_hl5_q <= side4_q.a[MAG_W-1:HALF_W] * cm4_q[HALF_W-1:0];
      pc_lh5_q <= side4_q.a[HALF_W-1:0] * cm4_q[MAG_W-1:HALF_W];
      pc_ll5_q <= side4_q.a[HALF_W-1:0] * cm4_q[HALF_W-1:0];

      side6_q <= side5_q;
      cneg6_q <= cneg5_q;
      bsq6_q  <= bsq6_d;
      acm6_q  <= acm6_d;

      side7_q <= side7_d;
      disc7_q <= disc7_d[SQ_W-1:0];
    end
  end

  assign valid_o     = v_q[6];
  assign coef_o.side = side7_q;
  assign coef_o.disc = disc7_q;

endmodule
`default_nettype wire

FILE: rtl/ssi_root.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_root: pipelined integer square root of disc * 2^(2T)
// Restoring method, one root bit per stage; the final remainder tells
// whether the root was exact (needed for the ceiling).
// ----------------------------------------------------------------------------
module ssi_root
  import ssi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  coef_t      coef_i,
  output logic       valid_o,
  output root_beat_t root_o
);

  typedef struct packed {
    side_t              side;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    logic [RADX_W-1:0]  rad;
  } sq_t;

  sq_t  init;
  sq_t  st_q [ROOT_W];
  logic v_q  [ROOT_W];

  always_comb begin
    init.side = coef_i.side;
    init.rem  = '0;
    init.root = '0;
    init.rad  = {coef_i.disc, {(2 * T_W){1'b0}}};
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
    sq_t              cur, nxt;
    logic             cv, ge;
    logic [REM_W-1:0] rem_n, trial;

    if (i == 0) begin : g_first
      assign cur = init;
      assign cv  = valid_i;
    end else begin : g_rest
      assign cur = st_q[i-1];
      assign cv  = v_q[i-1];
    end

    always_comb begin
      rem_n    = {cur.rem[REM_W-3:0], cur.rad[RADX_W-1 -: 2]};
      trial    = {cur.root, 2'b01};
      ge       = (rem_n >= trial);
      nxt.side = cur.side;
      nxt.rem  = ge ? (rem_n - trial) : rem_n;
      nxt.root = {cur.root[ROOT_W-2:0], ge};
      nxt.rad  = cur.rad << 2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign valid_o       = v_q[ROOT_W-1];
  assign root_o.side   = st_q[ROOT_W-1].side;
  assign root_o.root   = st_q[ROOT_W-1].root;
  assign root_o.rem_nz = |st_q[ROOT_W-1].rem;

endmodule
`default_nettype wire

FILE: rtl/ssi_quot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_quot: contact parameter t = floor((-b*S - ceil(S*sqrt(disc))) / a)
// Numerator stage, range check stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssi_quot
  import ssi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  root_beat_t root_i,
  output logic       valid_o,
  output tval_t      tval_o
);

  typedef struct packed {
    geom_t              geom;
    logic               miss;
    logic [MAG_W-1:0]   a;
    logic [ROOT_W-1:0]  rem;
    logic [T_W-1:0]     k;
  } dv_t;

  logic             v1_q, v2_q;
  logic             vd_q [T_W];
  geom_t            geom1_q;
  logic             miss1_q;
  logic [MAG_W-1:0] a1_q;
  nval_t            num1_q, num1_d;
  dv_t              dv2_q, dv2_d;
  dv_t              st_q [T_W];
  logic             over, neg;

  always_comb begin
    num1_d = -(nval_t'(root_i.side.b) <<< T_W) - nval_t'(root_i.root) -
             nval_t'(root_i.rem_nz);
  end

  always_comb begin
    // t >= 1 is a miss; a negative numerator means the start is inside
    over       = (num1_q >= nval_t'({a1_q, {T_W{1'b0}}}));
    neg        = num1_q[NUM_W-1];
    dv2_d.geom = geom1_q;
    dv2_d.miss = miss1_q | over;
    dv2_d.a    = a1_q;
    dv2_d.rem  = neg ? '0 : num1_q[ROOT_W-1:0];
    dv2_d.k    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geom1_q <= root_i.side.geom;
      miss1_q <= root_i.side.miss;
      a1_q    <= root_i.side.a;
      num1_q  <= num1_d;
      dv2_q   <= dv2_d;
    end
  end

  for (genvar i = 0; i < T_W; i++) begin : g_bit
    localparam int P = T_W - 1 - i;
    dv_t               cur, nxt;
    logic              cv, ge;
    logic [ROOT_W-1:0] shifted;

    if (i == 0) begin : g_first
      assign cur = dv2_q;
      assign cv  = v2_q;
    end else begin : g_rest
      assign cur = st_q[i-1];
      assign cv  = vd_q[i-1];
    end

    always_comb begin
      shifted  = ROOT_W'(cur.a) << P;
      ge       = (cur.rem >= shifted);
      nxt      = cur;
      nxt.rem  = ge ? (cur.rem - shifted) : cur.rem;
      nxt.k    = {cur.k[T_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[i] <= 1'b0;
      end else if (en_i) begin
        vd_q[i] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign valid_o     = vd_q[T_W-1];
  assign tval_o.geom = st_q[T_W-1].geom;
  assign tval_o.miss = st_q[T_W-1].miss;
  assign tval_o.k    = st_q[T_W-1].k;

endmodule
`default_nettype wire

FILE: rtl/ssi_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_point: contact point A + floor(k*d / 2^T) and result beat
// One multiply stage, one add stage; the second is the output register.
// ----------------------------------------------------------------------------
module ssi_point
  import ssi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  tval_t     tval_i,
  output logic      valid_o,
  output out_beat_t beat_o
);

  logic         v1_q, v2_q;
  coord_t       org1_q [3];
  pval_t        prod1_q [3];
  pval_t        prod1_d [3];
  logic         miss1_q;
  logic [T_W-1:0] k1_q;
  coord_t       pt [3];
  out_beat_t    beat_d, beat_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod1_d[i] = pval_t'($signed({1'b0, tval_i.k})) * pval_t'(tval_i.geom.dir[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = org1_q[i] + coord_t'(prod1_q[i] >>> T_W);
    end
    // a miss reports all zeros
    beat_d.hit     = !miss1_q;
    beat_d.param_t = miss1_q ? '0 : k1_q;
    beat_d.point_x = miss1_q ? '0 : pt[0];
    beat_d.point_y = miss1_q ? '0 : pt[1];
    beat_d.point_z = miss1_q ? '0 : pt[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        org1_q[i] <= tval_i.geom.org[i];
      end
      prod1_q <= prod1_d;
      miss1_q <= tval_i.miss;
      k1_q    <= tval_i.k;
      beat_q  <= beat_d;
    end
  end

  assign valid_o = v2_q;
  assign beat_o  = beat_q;

endmodule
`default_nettype wire
